@@ rtl/lmd_pkg.sv @@
// Shared types and constants for the label map dilation block.
package lmd_pkg;

    localparam int LABEL_W    = 12;
    localparam int COORD_W    = 10;
    localparam int KERNEL_MAX = 7;
    localparam int KDIM_W     = 3;
    localparam int KMASK_W    = 49;
    localparam int KBIT_W     = 6;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 49;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // item kinds carried on tuser
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_ALL  = 3'd5;

    // access to the selection store
    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [LABEL_W-1:0] addr;
        logic               data;
    } lmd_sel_req_t;

endpackage

@@ rtl/label_map_dilation_top.sv @@
// Label map dilation: label image store, selection store and kernel scan.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+------------------------------------------
//  s_*      | in        | s_tvalid/tready  | tuser: action; tdata: row, col, label, flag
//  m_*      | out       | m_tvalid/tready  | tdata: out_row, out_col, dilated_label
//  cfg_*    | in        | cfg_valid/ready  | cfg_index, cfg_data (always ready)
//
// Write and mark words are taken in the idle state, which they do not leave. A read of a
// labelled pixel passes the centre, here and done states before its result is registered;
// a read of a background pixel scans the kr*kc kernel cells (kernel sizes clamped to 1..7)
// through the single read port of the image memory, one kernel cell a cycle, then drains.
// A read outside the image goes straight to the done state and answers 0. After reset
// the selection store is swept clear, one label a cycle; s_tready stays low meanwhile,
// configuration is taken throughout. A finished result sits in the output register;
// a stalled m_tready holds it and the next word is taken while it waits.
module label_map_dilation_top
    import lmd_pkg::*;
#(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 1024,
    parameter int LABEL_COUNT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] row, [19:10] col, [31:20] label,
                                             // [32] select_flag, [39:33] zero
    input  logic [ACT_W-1:0]      s_tuser,   // [1:0] action
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [9:0] out_row, [19:10] out_col,
                                             // [31:20] dilated_label
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW        = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int RDW       = $clog2(MAX_ROWS + 1);
    localparam int CDW       = $clog2(MAX_COLS + 1);
    localparam int DIMW      = (RDW > 11) ? ((RDW > CDW) ? RDW : CDW)
                                          : ((CDW > 11) ? CDW : 11);
    localparam int SW        = COORD_W + 2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENTER = 3'd1;
    localparam logic [2:0] ST_HERE   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    // configuration
    logic [10:0]         image_rows_reg;
    logic [10:0]         image_cols_reg;
    logic [KDIM_W-1:0]   kernel_rows_reg;
    logic [KDIM_W-1:0]   kernel_cols_reg;
    logic [KMASK_W-1:0]  kernel_mask_reg;
    logic                select_all_reg;

    // control and datapath registers
    logic [2:0]          state_reg, state_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [LABEL_W-1:0]  here_reg, here_next;
    logic [LABEL_W-1:0]  best_reg, best_next;
    logic [LABEL_W-1:0]  result_reg, result_next;
    logic [KDIM_W-1:0]   m_cnt_reg, m_cnt_next;
    logic [KDIM_W-1:0]   n_cnt_reg, n_cnt_next;
    logic                p1_reg, p1_next;
    logic                p2_reg, p2_next;
    logic [LABEL_W-1:0]  lab2_reg, lab2_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // image memory
    logic [LABEL_W-1:0]  img_mem [IMG_DEPTH];
    logic [LABEL_W-1:0]  img_q_reg;
    logic                img_rd_en;
    logic [AW-1:0]       img_rd_addr;
    logic                img_we;
    logic [AW-1:0]       img_wr_addr;

    // selection store
    lmd_sel_req_t        sel_req;
    logic                sel_busy;
    logic                sel_hit;

    logic                s_fire;
    logic [COORD_W-1:0]  in_row;
    logic [COORD_W-1:0]  in_col;
    logic [LABEL_W-1:0]  in_label;
    logic                in_flag;
    logic                in_inside;
    logic [DIMW-1:0]     nr;
    logic [DIMW-1:0]     nc;
    logic [KDIM_W-1:0]   kr;
    logic [KDIM_W-1:0]   kc;
    logic [KDIM_W-1:0]   ro;
    logic [KDIM_W-1:0]   co;
    logic [SW-1:0]       src_r;
    logic [SW-1:0]       src_c;
    logic                cell_ok;
    logic                cell_last;
    logic                out_free;
    logic                lab2_sel;

    function automatic logic [AW-1:0] pix_addr(input logic [COORD_W:0] r,
                                               input logic [COORD_W:0] c);
        pix_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    function automatic logic [KBIT_W-1:0] kbit_idx(input logic [KDIM_W-1:0] m,
                                                   input logic [KDIM_W-1:0] n);
        kbit_idx = KBIT_W'(m) * KBIT_W'(KERNEL_MAX) + KBIT_W'(n);
    endfunction

    assign in_row   = s_tdata[9:0];
    assign in_col   = s_tdata[19:10];
    assign in_label = s_tdata[31:20];
    assign in_flag  = s_tdata[32];

    assign s_tready  = (state_reg == ST_IDLE) && !sel_busy;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // image size clamped to 1..MAX
    assign nr = (image_rows_reg == 11'd0) ? DIMW'(1)
              : ((DIMW'(image_rows_reg) > DIMW'(MAX_ROWS)) ? DIMW'(MAX_ROWS)
                                                           : DIMW'(image_rows_reg));
    assign nc = (image_cols_reg == 11'd0) ? DIMW'(1)
              : ((DIMW'(image_cols_reg) > DIMW'(MAX_COLS)) ? DIMW'(MAX_COLS)
                                                           : DIMW'(image_cols_reg));
    assign in_inside = (DIMW'(in_row) < nr) && (DIMW'(in_col) < nc);

    // kernel size clamped to 1..KERNEL_MAX, centre offset
    assign kr = (kernel_rows_reg == '0) ? KDIM_W'(1)
              : ((kernel_rows_reg > KDIM_W'(KERNEL_MAX)) ? KDIM_W'(KERNEL_MAX)
                                                         : kernel_rows_reg);
    assign kc = (kernel_cols_reg == '0) ? KDIM_W'(1)
              : ((kernel_cols_reg > KDIM_W'(KERNEL_MAX)) ? KDIM_W'(KERNEL_MAX)
                                                         : kernel_cols_reg);
    assign ro = (kr - 1'b1) >> 1;
    assign co = (kc - 1'b1) >> 1;

    // source pixel that reaches the read position through cell (m,n);
    // top bit set means it fell above or left of the image
    assign src_r = SW'(row_reg) + SW'(ro) - SW'(m_cnt_reg);
    assign src_c = SW'(col_reg) + SW'(co) - SW'(n_cnt_reg);
    assign cell_ok = !((m_cnt_reg == ro) && (n_cnt_reg == co))
                   && kernel_mask_reg[kbit_idx(m_cnt_reg, n_cnt_reg)]
                   && !src_r[SW-1] && !src_c[SW-1]
                   && (DIMW'(src_r[SW-2:0]) < nr) && (DIMW'(src_c[SW-2:0]) < nc);
    assign cell_last = (m_cnt_reg == kr - 1'b1) && (n_cnt_reg == kc - 1'b1);

    assign lab2_sel = select_all_reg || sel_hit;

    // image memory port control
    always_comb
    begin
        img_rd_en   = 1'b0;
        img_rd_addr = pix_addr({1'b0, in_row}, {1'b0, in_col});
        img_we      = 1'b0;
        img_wr_addr = pix_addr({1'b0, in_row}, {1'b0, in_col});
        if (state_reg == ST_SCAN)
        begin
            img_rd_en   = cell_ok;
            img_rd_addr = pix_addr(src_r[SW-2:0], src_c[SW-2:0]);
        end
        else if (s_fire && in_inside)
        begin
            img_rd_en = (s_tuser == ACT_READ);
            img_we    = (s_tuser == ACT_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_wr_addr] <= in_label;
        end
    end

    always_ff @(posedge clk)
    begin
        if (img_rd_en)
        begin
            img_q_reg <= img_mem[img_rd_addr];
        end
    end

    // selection store access
    always_comb
    begin
        sel_req = '0;
        if (s_fire && (s_tuser == ACT_MARK))
        begin
            sel_req.wr   = 1'b1;
            sel_req.addr = in_label;
            sel_req.data = in_flag;
        end
        else if ((state_reg == ST_CENTER || p1_reg) && (img_q_reg != '0))
        begin
            sel_req.rd   = 1'b1;
            sel_req.addr = img_q_reg;
        end
    end

    lmd_sel_mem #(
        .LABEL_COUNT (LABEL_COUNT)
    ) u_sel (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sel_req),
        .busy  (sel_busy),
        .hit   (sel_hit)
    );

    // sequencer and neighbour pipeline:
    // cell issue -> image data (p1) -> selection bit (p2) -> minimum
    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        here_next     = here_reg;
        best_next     = best_reg;
        result_next   = result_reg;
        m_cnt_next    = m_cnt_reg;
        n_cnt_next    = n_cnt_reg;
        p1_next       = 1'b0;
        p2_next       = 1'b0;
        lab2_next     = lab2_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (p1_reg)
        begin
            p2_next   = (img_q_reg != '0);
            lab2_next = img_q_reg;
        end
        if (p2_reg && lab2_sel && ((best_reg == '0) || (lab2_reg < best_reg)))
        begin
            best_next = lab2_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser == ACT_READ))
                begin
                    row_next    = in_row;
                    col_next    = in_col;
                    result_next = '0;
                    state_next  = in_inside ? ST_CENTER : ST_DONE;
                end
            end
            ST_CENTER:
            begin
                here_next  = img_q_reg;
                best_next  = '0;
                m_cnt_next = '0;
                n_cnt_next = '0;
                state_next = (img_q_reg != '0) ? ST_HERE : ST_SCAN;
            end
            ST_HERE:
            begin
                // labelled pixel keeps its label unless selected with centre bit clear
                if (!lab2_sel)
                begin
                    result_next = here_reg;
                end
                else
                begin
                    result_next = kernel_mask_reg[kbit_idx(ro, co)] ? here_reg : '0;
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                p1_next = cell_ok;
                if (cell_last)
                begin
                    state_next = ST_DRAIN;
                end
                else if (n_cnt_reg == kc - 1'b1)
                begin
                    n_cnt_next = '0;
                    m_cnt_next = m_cnt_reg + 1'b1;
                end
                else
                begin
                    n_cnt_next = n_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_reg && !p2_reg)
                begin
                    result_next = best_reg;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {result_reg, col_reg, row_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_cnt_reg    <= '0;
            n_cnt_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            m_tvalid_reg <= m_tvalid_next;
            m_cnt_reg    <= m_cnt_next;
            n_cnt_reg    <= n_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        here_reg    <= here_next;
        best_reg    <= best_next;
        result_reg  <= result_next;
        lab2_reg    <= lab2_next;
        m_tdata_reg <= m_tdata_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg  <= 11'd1024;
            image_cols_reg  <= 11'd1024;
            kernel_rows_reg <= 3'd3;
            kernel_cols_reg <= 3'd3;
            kernel_mask_reg <= 49'd115591;
            select_all_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data[10:0];
                CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data[10:0];
                CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[KDIM_W-1:0];
                CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[KDIM_W-1:0];
                CFG_KERNEL_MASK: kernel_mask_reg <= cfg_data[KMASK_W-1:0];
                CFG_SELECT_ALL:  select_all_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/lmd_sel_mem.sv @@
// Label selection store: one bit per label, cleared by a sweep after reset.
module lmd_sel_mem
    import lmd_pkg::*;
#(
    parameter int LABEL_COUNT = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  lmd_sel_req_t req,
    output logic         busy,
    output logic         hit
);

    localparam int SEL_DEPTH = (LABEL_COUNT < (1 << LABEL_W)) ? LABEL_COUNT : (1 << LABEL_W);
    localparam int SAW       = (SEL_DEPTH > 1) ? $clog2(SEL_DEPTH) : 1;

    logic                mem [SEL_DEPTH];
    logic [SAW-1:0]      clr_cnt_reg;
    logic [SAW-1:0]      clr_cnt_next;
    logic                clr_busy_reg;
    logic                clr_busy_next;
    logic                rd_bit_reg;
    logic                rd_range_reg;
    logic                in_range;

    // labels at or above the depth never count as selected
    assign in_range = ({1'b0, req.addr} < (LABEL_W + 1)'(SEL_DEPTH));

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == SAW'(SEL_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
                clr_cnt_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (req.wr && in_range)
        begin
            mem[req.addr[SAW-1:0]] <= req.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            rd_bit_reg   <= in_range ? mem[req.addr[SAW-1:0]] : 1'b0;
            rd_range_reg <= in_range;
        end
    end

    assign busy = clr_busy_reg;
    assign hit  = rd_bit_reg & rd_range_reg;

endmodule

@@ rtl/lmd_checker.sv @@
// Port-level checks for the label map dilation block, bound to the top level.
module lmd_checker
    import lmd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [ACT_W-1:0]      s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a write, mark or unused-action word never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != ACT_READ) |=> !$rose(m_tvalid))
        else $error("result appeared after a non-read word");

    // s_tready drops once a read is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_READ) |=> !s_tready)
        else $error("new word taken while a read is in progress");

endmodule

bind label_map_dilation_top lmd_checker u_lmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb.sv @@
// Self-checking testbench for label_map_dilation_top: random and directed words.
`timescale 1ns / 1ps

module tb
    import lmd_pkg::*;
();

    localparam int MAX_DIM     = 1024;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 64;       // longest read (7x7 kernel) plus margin
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 100;

    localparam logic [ACT_W-1:0]     ACT_NONE      = 2'd3;   // unused action
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;   // beyond register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [LABEL_W-1:0] label;
        logic               flag;
    } pixel_word_t;

    // same layout as m_tdata: row in the low bits
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pixel_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [ACT_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [10:0]          img_rows_reg = 11'd1024;
    logic [10:0]          img_cols_reg = 11'd1024;
    logic [KDIM_W-1:0]    k_rows_reg = 3'd3;
    logic [KDIM_W-1:0]    k_cols_reg = 3'd3;
    logic [KMASK_W-1:0]   k_mask_reg = 49'd115591;
    logic                 sel_all_reg = 1'b1;
    logic [LABEL_W-1:0]   label_image [int];
    bit                   label_chosen [0:4095];

    // stimulus side
    bit                   pixel_known [int];   // pixels a queued write will fill
    pixel_word_t          pending_words [$];
    pixel_result_t        expected_pixels [$];
    pixel_word_t          word_on_bus;
    int                   unaccepted_words = 0;
    int                   src_idle_pct = 0;
    int                   sink_stall_pct = 0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   win_r0, win_c0, win_h, win_w;
    int                   label_pool [0:3];

    label_map_dilation_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [LABEL_W-1:0] stored_label(int r, int c);
        if (label_image.exists(r * MAX_DIM + c))
            return label_image[r * MAX_DIM + c];
        return '0;
    endfunction

    function automatic bit is_chosen(logic [LABEL_W-1:0] lab);
        return sel_all_reg || label_chosen[lab];
    endfunction

    // dilated label of an in-image pixel under the current settings
    function automatic logic [LABEL_W-1:0] dilate_pixel(int r, int c, int nr, int nc);
        int                 kr, kc, ro, co, sr, sc;
        logic [LABEL_W-1:0] here, lab, best;
        kr   = clamp_dim(int'(k_rows_reg), KERNEL_MAX);
        kc   = clamp_dim(int'(k_cols_reg), KERNEL_MAX);
        ro   = (kr - 1) / 2;
        co   = (kc - 1) / 2;
        here = stored_label(r, c);
        best = '0;
        if (here != 0)
        begin
            if (!is_chosen(here))
                return here;
            return k_mask_reg[ro * KERNEL_MAX + co] ? here : '0;
        end
        // source pixel (r-m+ro, c-n+co) reaches (r,c) through kernel cell (m,n)
        for (int m = 0; m < kr; m++)
        begin
            for (int n = 0; n < kc; n++)
            begin
                if ((m == ro && n == co) || !k_mask_reg[m * KERNEL_MAX + n])
                    continue;
                sr = r - m + ro;
                sc = c - n + co;
                if (sr < 0 || sc < 0 || sr >= nr || sc >= nc)
                    continue;
                lab = stored_label(sr, sc);
                if (lab == 0 || !is_chosen(lab))
                    continue;
                if (best == 0 || lab < best)
                    best = lab;
            end
        end
        return best;
    endfunction

    // update the predictor with one accepted word
    function automatic void absorb_word(pixel_word_t w);
        int            nr, nc;
        bit            in_image;
        pixel_result_t res;
        nr       = clamp_dim(int'(img_rows_reg), MAX_DIM);
        nc       = clamp_dim(int'(img_cols_reg), MAX_DIM);
        in_image = (int'(w.row) < nr) && (int'(w.col) < nc);
        case (w.action)
            ACT_WRITE:
                if (in_image)
                    label_image[int'(w.row) * MAX_DIM + int'(w.col)] = w.label;
            ACT_MARK:
                label_chosen[w.label] = w.flag;
            ACT_READ:
            begin
                res.row   = w.row;
                res.col   = w.col;
                res.label = in_image ? dilate_pixel(int'(w.row), int'(w.col), nr, nc) : '0;
                expected_pixels.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void put_word(logic [ACT_W-1:0] act, int r, int c, int lab, bit flag);
        pixel_word_t w;
        w.action = act;
        w.row    = COORD_W'(r);
        w.col    = COORD_W'(c);
        w.label  = LABEL_W'(lab);
        w.flag   = flag;
        pending_words.push_back(w);
        unaccepted_words++;
    endfunction

    function automatic int pick_label();
        case ($urandom_range(9))
            0, 1, 2, 3: return 0;
            8:          return 4095;
            9:          return $urandom_range(4095);
            default:    return label_pool[$urandom_range(3)];
        endcase
    endfunction

    function automatic void queue_write(int r, int c, int lab);
        if (r < clamp_dim(int'(img_rows_reg), MAX_DIM)
            && c < clamp_dim(int'(img_cols_reg), MAX_DIM))
            pixel_known[r * MAX_DIM + c] = 1'b1;
        put_word(ACT_WRITE, r, c, lab, 1'($urandom_range(1)));
    endfunction

    // read a pixel, first filling every in-image pixel the read may look at
    function automatic void cover_read(int r, int c);
        int nr, nc, kr, kc, ro, co, sr, sc;
        nr = clamp_dim(int'(img_rows_reg), MAX_DIM);
        nc = clamp_dim(int'(img_cols_reg), MAX_DIM);
        kr = clamp_dim(int'(k_rows_reg), KERNEL_MAX);
        kc = clamp_dim(int'(k_cols_reg), KERNEL_MAX);
        ro = (kr - 1) / 2;
        co = (kc - 1) / 2;
        if (r < nr && c < nc)
        begin
            for (int m = 0; m < kr; m++)
            begin
                for (int n = 0; n < kc; n++)
                begin
                    if (!((m == ro && n == co) || k_mask_reg[m * KERNEL_MAX + n]))
                        continue;
                    sr = r - m + ro;
                    sc = c - n + co;
                    if (sr < 0 || sc < 0 || sr >= nr || sc >= nc)
                        continue;
                    if (!pixel_known.exists(sr * MAX_DIM + sc))
                        queue_write(sr, sc, pick_label());
                end
            end
        end
        put_word(ACT_READ, r, c, $urandom_range(4095), 1'($urandom_range(1)));
    endfunction

    // the first coordinate past the edge of the image, or a random one below MAX_DIM
    function automatic int edge_coord(int n);
        if (n < MAX_DIM && $urandom_range(1))
            return n;
        return $urandom_range(MAX_DIM - 1);
    endfunction

    function automatic logic [10:0] pick_dim();
        case ($urandom_range(9))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;
            3:       return 11'd1024;
            default: return 11'($urandom_range(24, 2));
        endcase
    endfunction

    function automatic void gen_random_word();
        int r, c, pick;
        r    = win_r0 + $urandom_range(win_h - 1);
        c    = win_c0 + $urandom_range(win_w - 1);
        pick = $urandom_range(99);
        if (pick < 30)
            queue_write(r, c, pick_label());
        else if (pick < 40)
            put_word(ACT_MARK, $urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1),
                     ($urandom_range(3) == 0) ? $urandom_range(4095) : pick_label(),
                     1'($urandom_range(1)));
        else if (pick < 85)
            cover_read(r, c);
        else if (pick < 93)
        begin
            r = edge_coord(clamp_dim(int'(img_rows_reg), MAX_DIM));
            c = edge_coord(clamp_dim(int'(img_cols_reg), MAX_DIM));
            if (pick < 89)
                queue_write(r, c, pick_label());
            else
                cover_read(r, c);
        end
        else
            put_word(ACT_NONE, $urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1),
                     $urandom_range(4095), 1'($urandom_range(1)));
    endfunction

    // one register write; the predictor copy follows at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_IMAGE_ROWS:  img_rows_reg = value[10:0];
            CFG_IMAGE_COLS:  img_cols_reg = value[10:0];
            CFG_KERNEL_ROWS: k_rows_reg   = value[KDIM_W-1:0];
            CFG_KERNEL_COLS: k_cols_reg   = value[KDIM_W-1:0];
            CFG_KERNEL_MASK: k_mask_reg   = value[KMASK_W-1:0];
            CFG_SELECT_ALL:  sel_all_reg  = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (unaccepted_words != 0 || expected_pixels.size() != 0)
            @(posedge clk);
        // words with no result may still be in the pipe
        repeat (SETTLE) @(posedge clk);
    endtask

    // input word driver; the predictor sees each word at its handshake
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_word(word_on_bus);
                unaccepted_words--;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    word_on_bus = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - 33){1'b0}}, word_on_bus.flag, word_on_bus.label,
                                 word_on_bus.col, word_on_bus.row};
                    s_tuser  <= word_on_bus.action;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk)
    begin
        pixel_result_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: row %0d col %0d label %0d",
                                 got.row, got.col, got.label);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.row !== want.row || got.col !== want.col || got.label !== want.label)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected row %0d col %0d label %0d, ",
                                      "got row %0d col %0d label %0d"},
                                     want.row, want.col, want.label,
                                     got.row, got.col, got.label);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [10:0]           rows_v, cols_v;
        logic [KDIM_W-1:0]     krows_v, kcols_v;
        logic [63:0]           rnd64;
        logic [CFG_DATA_W-1:0] mask_v;
        logic                  sel_v;
        int                    nr, nc;

        label_pool[0] = 1;
        label_pool[1] = 2;
        label_pool[2] = 5;
        label_pool[3] = 4095;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, on reset settings: full image, 3x3 kernel, all labels expand
        put_word(ACT_MARK, 0, 0, 0, 1'b1);              // marking label zero
        put_word(ACT_MARK, 0, 0, 4095, 1'b1);
        queue_write(1023, 1023, 4095);
        cover_read(1023, 1023);                         // far corner, largest label
        queue_write(0, 0, 0);
        cover_read(0, 0);                               // background at origin
        queue_write(0, 1, 0);
        cover_read(0, 1);
        put_word(ACT_NONE, 1023, 1023, 4095, 1'b1);     // unused action, all ones
        wait_idle();

        // directed, small image with a 5x3 kernel whose centre is clear
        mask_v     = '1;
        mask_v[15] = 1'b0;
        write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(5));
        write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(7));
        write_reg(CFG_KERNEL_ROWS, CFG_DATA_W'(5));
        write_reg(CFG_KERNEL_COLS, CFG_DATA_W'(3));
        write_reg(CFG_KERNEL_MASK, mask_v);
        write_reg(CFG_SELECT_ALL, CFG_DATA_W'(0));
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        cfg_valid <= 1'b0;
        put_word(ACT_MARK, 0, 0, 3, 1'b1);
        put_word(ACT_MARK, 0, 0, 4095, 1'b1);
        put_word(ACT_MARK, 0, 0, 7, 1'b0);
        queue_write(2, 3, 3);
        cover_read(2, 3);                               // selected, centre clear: 0
        queue_write(4, 6, 7);
        cover_read(4, 6);                               // unselected keeps its label
        queue_write(0, 0, 0);
        cover_read(0, 0);
        queue_write(5, 0, 9);                           // outside: dropped
        cover_read(5, 0);
        cover_read(0, 7);
        cover_read(1023, 1023);
        put_word(ACT_MARK, 0, 0, 3, 1'b0);
        cover_read(2, 3);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            rnd64 = {$urandom, $urandom};
            if (phase == 0)
            begin
                rows_v = 11'd0;  cols_v = 11'd2047;
                krows_v = 3'd0;  kcols_v = 3'd7;
                mask_v = '1;     sel_v = 1'b1;
            end
            else if (phase == 1)
            begin
                rows_v = 11'd2047; cols_v = 11'd1;
                krows_v = 3'd7;    kcols_v = 3'd0;
                mask_v = '0;       sel_v = 1'b0;
            end
            else
            begin
                rows_v  = pick_dim();
                cols_v  = pick_dim();
                krows_v = KDIM_W'($urandom_range(7));
                kcols_v = KDIM_W'($urandom_range(7));
                case ($urandom_range(3))
                    0:       mask_v = '1;
                    1:       mask_v = rnd64[KMASK_W-1:0] & rnd64[63:15];
                    default: mask_v = rnd64[KMASK_W-1:0];
                endcase
                sel_v = 1'($urandom_range(1));
            end
            write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(rows_v));
            write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(cols_v));
            write_reg(CFG_KERNEL_ROWS, CFG_DATA_W'(krows_v));
            write_reg(CFG_KERNEL_COLS, CFG_DATA_W'(kcols_v));
            write_reg(CFG_KERNEL_MASK, mask_v);
            write_reg(CFG_SELECT_ALL, CFG_DATA_W'(sel_v));
            cfg_valid <= 1'b0;

            case (phase % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 70; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 70; end
                default: begin src_idle_pct = 17; sink_stall_pct = 17; end
            endcase

            // work window: near a corner, the far corner or anywhere
            nr    = clamp_dim(int'(img_rows_reg), MAX_DIM);
            nc    = clamp_dim(int'(img_cols_reg), MAX_DIM);
            win_h = clamp_dim($urandom_range(10, 2), nr);
            win_w = clamp_dim($urandom_range(10, 2), nc);
            case ($urandom_range(2))
                0:       begin win_r0 = 0;          win_c0 = 0;          end
                1:       begin win_r0 = nr - win_h; win_c0 = nc - win_w; end
                default: begin win_r0 = $urandom_range(nr - win_h);
                               win_c0 = $urandom_range(nc - win_w); end
            endcase
            label_pool[1] = $urandom_range(15, 2);
            label_pool[2] = $urandom_range(4094, 16);

            for (int i = 0; i < PHASE_WORDS; i++)
                gen_random_word();
        end

        wait_idle();
        mismatch_count += expected_pixels.size();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
